/* rtl/mjaf_pkg.sv */
// ----------------------------------------------------------------------------
// mjaf_pkg
// Shared types, widths and codes for the multiclass job admission FIFO.
// ----------------------------------------------------------------------------
package mjaf_pkg;

  // Default sizing of the block.
  localparam int DEF_NUM_CLASSES = 4;
  localparam int DEF_NUM_CONFIGS = 8;
  localparam int DEF_COUNT_BITS  = 8;
  localparam int DEF_FIFO_DEPTH  = 64;

  // Fixed field and register widths.
  localparam int CLASS_W      = 2;
  localparam int OCC_W        = 9;
  localparam int CNT_OUT_W    = 7;
  localparam int ROW_W        = 32;
  localparam int NUM_ROW_REGS = 8;
  localparam int CFG_IDX_W    = 3;

  // Command codes.
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  // One request as it leaves the front part.
  typedef struct packed {
    logic               cmd;
    logic [CLASS_W-1:0] cls;
    logic               cls_ok;
  } job_req_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_DEPART,
    ST_RDHEAD,
    ST_CHECK,
    ST_DONE
  } eng_state_t;

endpackage

/* rtl/mjaf_ram.sv */
// ----------------------------------------------------------------------------
// mjaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mjaf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mjaf_front.sv */
// ----------------------------------------------------------------------------
// mjaf_front
// Accepts requests, checks the class against the configured class count and
// holds them in a two-entry queue towards the back end.
// ----------------------------------------------------------------------------
module mjaf_front import mjaf_pkg::*; #(
  parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [CLASS_W-1:0] job_class,
  output logic               req_valid,
  output job_req_t           req,
  input  logic               req_pop
);

  job_req_t    slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  job_req_t    incoming;

  // Classify the incoming request.
  always_comb begin
    incoming.cmd    = command;
    incoming.cls    = job_class;
    incoming.cls_ok = (32'(job_class) < NUM_CLASSES);
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign req_valid = (count != 2'd0);
  assign req       = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (req_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(req_pop);
    end
  end

endmodule

/* rtl/mjaf_engine.sv */
// ----------------------------------------------------------------------------
// mjaf_engine
// Back end: holds the configuration rows, running and waiting counts and the
// waiting FIFO, carries out one request at a time and registers the result.
// ----------------------------------------------------------------------------
module mjaf_engine import mjaf_pkg::*; #(
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int NUM_CONFIGS = DEF_NUM_CONFIGS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int FIFO_DEPTH  = DEF_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  input  logic                 req_valid,
  input  job_req_t             req,
  output logic                 req_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 handled_now,
  output logic                 queued,
  output logic                 dropped,
  output logic [CNT_OUT_W-1:0] drained_count,
  output logic [OCC_W-1:0]     class_occupancy,
  output logic [CNT_OUT_W-1:0] queue_length
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = ((COUNT_BITS > FILL_W) ? COUNT_BITS : FILL_W) + 1;

  logic [ROW_W-1:0]      rows [NUM_CONFIGS];
  logic [COUNT_BITS-1:0] entry [NUM_CONFIGS][NUM_CLASSES];
  logic [COUNT_BITS-1:0] running [NUM_CLASSES];
  logic [FILL_W-1:0]     waiting [NUM_CLASSES];
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     drained;
  eng_state_t            state;
  eng_state_t            state_next;
  job_req_t              cur;
  logic                  res_handled;
  logic                  res_queued;
  logic                  res_dropped;
  logic [OCC_W-1:0]      res_occ;
  logic [CLASS_W-1:0]    head_cls;
  logic [CLASS_W-1:0]    fit_cls;
  logic                  fits;
  logic [COUNT_BITS-1:0] cur_running;
  logic [FILL_W-1:0]     cur_waiting;
  logic                  ram_we;
  logic                  load_out;

  // Configuration rows; writes beyond the used rows are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_CONFIGS; r++) begin
        rows[r] <= '0;
      end
    end else if (cfg_we) begin
      for (int r = 0; r < NUM_CONFIGS; r++) begin
        if (32'(cfg_index) == r) begin
          rows[r] <= cfg_data;
        end
      end
    end
  end

  // Per-class row entries; classes lying past bit 31 read as zero.
  for (genvar r = 0; r < NUM_CONFIGS; r++) begin : g_row
    for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cls
      localparam int LO = i * COUNT_BITS;
      if (LO >= ROW_W) begin : g_zero
        assign entry[r][i] = '0;
      end else begin : g_field
        assign entry[r][i] = COUNT_BITS'(rows[r] >> LO);
      end
    end
  end

  // Feasibility check with one more job of fit_cls running.
  always_comb begin
    logic                ok;
    logic [COUNT_BITS:0] want;
    fits = 1'b0;
    for (int r = 0; r < NUM_CONFIGS; r++) begin
      ok = 1'b1;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        want = {1'b0, running[i]} + (COUNT_BITS+1)'(32'(fit_cls) == i);
        if (want > {1'b0, entry[r][i]}) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        fits = 1'b1;
      end
    end
  end

  assign fit_cls = (state == ST_CHECK) ? head_cls : cur.cls;

  // Counts of the current request's class.
  always_comb begin
    cur_running = '0;
    cur_waiting = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (32'(cur.cls) == i) begin
        cur_running = running[i];
        cur_waiting = waiting[i];
      end
    end
  end

  assign ram_we   = (state == ST_ARRIVE) && !fits && (32'(fill) < FIFO_DEPTH);
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // Waiting FIFO storage; the read address follows the head.
  mjaf_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (FIFO_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cur.cls),
    .raddr (head),
    .rdata (head_cls)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and request pop.
  always_comb begin
    state_next = state;
    req_pop    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          if (!req.cls_ok) begin
            state_next = ST_DONE;
          end else if (req.cmd == CMD_ARRIVE) begin
            state_next = ST_ARRIVE;
          end else begin
            state_next = ST_DEPART;
          end
        end
      end
      ST_ARRIVE: state_next = ST_DONE;
      ST_DEPART: state_next = ST_RDHEAD;
      ST_RDHEAD: state_next = (fill == '0) ? ST_DONE : ST_CHECK;
      ST_CHECK:  state_next = fits ? ST_RDHEAD : ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Counts, FIFO pointers and result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        running[i] <= '0;
        waiting[i] <= '0;
      end
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cur         <= req;
          res_handled <= 1'b0;
          res_queued  <= 1'b0;
          res_dropped <= 1'b0;
          res_occ     <= '0;
          drained     <= '0;
        end
        ST_ARRIVE: begin
          res_occ <= OCC_W'(SUM_W'(cur_running) + SUM_W'(cur_waiting));
          if (fits) begin
            res_handled <= 1'b1;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              if (32'(cur.cls) == i) begin
                running[i] <= running[i] + 1'b1;
              end
            end
          end else if (ram_we) begin
            res_queued <= 1'b1;
            tail       <= (tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
            fill       <= fill + 1'b1;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              if (32'(cur.cls) == i) begin
                waiting[i] <= waiting[i] + 1'b1;
              end
            end
          end else begin
            res_dropped <= 1'b1;
          end
        end
        ST_DEPART: begin
          if (cur_running != '0) begin
            res_handled <= 1'b1;
            for (int i = 0; i < NUM_CLASSES; i++) begin
              if (32'(cur.cls) == i) begin
                running[i] <= running[i] - 1'b1;
              end
            end
          end
        end
        ST_CHECK: begin
          // Start the FIFO head when it fits.
          if (fits) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
              if (32'(head_cls) == i) begin
                running[i] <= running[i] + 1'b1;
                if (waiting[i] != '0) begin
                  waiting[i] <= waiting[i] - 1'b1;
                end
              end
            end
            head    <= (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
            fill    <= fill - 1'b1;
            drained <= drained + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      handled_now     <= res_handled;
      queued          <= res_queued;
      dropped         <= res_dropped;
      drained_count   <= CNT_OUT_W'(drained);
      class_occupancy <= res_occ;
      queue_length    <= CNT_OUT_W'(fill);
    end
  end

endmodule

/* rtl/multiclass_job_admission_fifo.sv */
// ----------------------------------------------------------------------------
// multiclass_job_admission_fifo
// Admits jobs of several classes against a set of feasible configurations.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue in the front part and are carried out one
// at a time by the back-end sequencer, which delivers one result per request
// through an output register. An arrival runs through ARRIVE and DONE, a
// departure through DEPART, RDHEAD, a CHECK and RDHEAD per job started from
// the waiting FIFO, one more CHECK when a waiting head does not fit, and DONE;
// the drain loop is bound by the registered FIFO memory read and then the
// feasibility check. The user must write configuration rows through the plain
// write port only while idle; the block does not enforce it. Classes at or
// above the class count are ignored and report only the queue length.
module multiclass_job_admission_fifo import mjaf_pkg::*; #(
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int NUM_CONFIGS = DEF_NUM_CONFIGS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int FIFO_DEPTH  = DEF_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [CLASS_W-1:0]   job_class,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 handled_now,
  output logic                 queued,
  output logic                 dropped,
  output logic [CNT_OUT_W-1:0] drained_count,
  output logic [OCC_W-1:0]     class_occupancy,
  output logic [CNT_OUT_W-1:0] queue_length
);

  logic     req_valid;
  logic     req_pop;
  job_req_t req;

  // Front part: acceptance and classification.
  mjaf_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .job_class (job_class),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  // Back part: admission, draining and result.
  mjaf_engine #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_CONFIGS (NUM_CONFIGS),
    .COUNT_BITS  (COUNT_BITS),
    .FIFO_DEPTH  (FIFO_DEPTH)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_valid),
    .req             (req),
    .req_pop         (req_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .handled_now     (handled_now),
    .queued          (queued),
    .dropped         (dropped),
    .drained_count   (drained_count),
    .class_occupancy (class_occupancy),
    .queue_length    (queue_length)
  );

  // At most one admission outcome per result.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({handled_now && !dropped, queued, dropped}))
    else $error("more than one admission outcome");

  // A drop only happens with the FIFO full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> (32'(queue_length) == FIFO_DEPTH))
    else $error("drop with room in the FIFO");

  // An arrival never drains and a queued arrival leaves a non-empty FIFO.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queued) |-> (drained_count == '0 && queue_length != '0))
    else $error("queued result inconsistent");

  // The queue length never exceeds the FIFO depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(queue_length) <= FIFO_DEPTH))
    else $error("queue length beyond depth");

endmodule
